[design/sgcs_pkg.sv]
// ============================================================================
// sgcs_pkg
// Shared types, constants and microcode table for the stereo gain chase
// cubic saturator.
// ============================================================================
`default_nettype none

package sgcs_pkg;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 17;
   localparam int SPEED_W  = 28;
   localparam int PROD_W   = 60;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [CSR_AW-1:0] ADDR_TRIM_GAIN = 2'd0;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN   = 17'd65536;
   localparam logic [SPEED_W-1:0] SPEED_FLOOR  = 28'd22937600;   // 350.0
   localparam logic [SPEED_W-1:0] SPEED_CAP    = 28'd163840000;  // 2500.0
   localparam logic [SPEED_W-1:0] SPEED_FLOOR_PLUS_SUB = 28'd22938255;
   localparam logic [SPEED_W-1:0] DECAY_SUB    = 28'd655;        // 0.01
   localparam logic [31:0]        DECAY_MUL    = 32'd4294537799; // 0.9999

   typedef enum logic [3:0] {
      OP_NOP,
      OP_PREP,
      OP_DECAY,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SCALE,
      OP_SQUARE,
      OP_CUBE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      MA_SPEED,
      MA_GAIN,
      MA_MAG,
      MA_Y
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_DECAY,
      MB_SPEED,
      MB_GAIN,
      MB_Y,
      MB_SQ
   } mul_b_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_DIV,
      HOLD_OUT
   } hold_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_LEFT
   } jump_type;

   typedef logic [3:0] upc_type;

   localparam upc_type UPC_IDLE      = 4'd0;
   localparam upc_type UPC_PREP      = 4'd1;
   localparam upc_type UPC_MUL_DECAY = 4'd2;
   localparam upc_type UPC_DECAY     = 4'd3;
   localparam upc_type UPC_MUL_CHASE = 4'd4;
   localparam upc_type UPC_DIV_INIT  = 4'd5;
   localparam upc_type UPC_DIV_STEP  = 4'd6;
   localparam upc_type UPC_MUL_SCALE = 4'd7;
   localparam upc_type UPC_SCALE     = 4'd8;
   localparam upc_type UPC_MUL_SQ    = 4'd9;
   localparam upc_type UPC_SQUARE    = 4'd10;
   localparam upc_type UPC_MUL_CUBE  = 4'd11;
   localparam upc_type UPC_CUBE      = 4'd12;
   localparam upc_type UPC_EMIT      = 4'd13;

   typedef struct packed {
      op_type    op;
      logic      mul_en;
      mul_a_type mul_a;
      mul_b_type mul_b;
      hold_type  hold;
      jump_type  jump;
      upc_type   target;
   } uword_type;

   typedef struct packed {
      op_type    op;
      logic      mul_en;
      mul_a_type mul_a;
      mul_b_type mul_b;
      logic      load;
   } dp_ctl_type;

   typedef struct packed {
      logic div_busy;
      logic ch_right;
   } dp_status_type;

   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      w.op     = OP_NOP;
      w.mul_en = 1'b0;
      w.mul_a  = MA_SPEED;
      w.mul_b  = MB_DECAY;
      w.hold   = HOLD_NONE;
      w.jump   = JMP_NONE;
      w.target = UPC_IDLE;
      case (upc)
         UPC_IDLE: begin
            w.hold = HOLD_REQ;
         end
         UPC_PREP: begin
            w.op = OP_PREP;
         end
         UPC_MUL_DECAY: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_SPEED;
            w.mul_b  = MB_DECAY;
         end
         UPC_DECAY: begin
            w.op = OP_DECAY;
         end
         UPC_MUL_CHASE: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_GAIN;
            w.mul_b  = MB_SPEED;
         end
         UPC_DIV_INIT: begin
            w.op = OP_DIV_INIT;
         end
         UPC_DIV_STEP: begin
            w.op   = OP_DIV_STEP;
            w.hold = HOLD_DIV;
         end
         UPC_MUL_SCALE: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_MAG;
            w.mul_b  = MB_GAIN;
         end
         UPC_SCALE: begin
            w.op = OP_SCALE;
         end
         UPC_MUL_SQ: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_Y;
            w.mul_b  = MB_Y;
         end
         UPC_SQUARE: begin
            w.op = OP_SQUARE;
         end
         UPC_MUL_CUBE: begin
            w.mul_en = 1'b1;
            w.mul_a  = MA_Y;
            w.mul_b  = MB_SQ;
         end
         UPC_CUBE: begin
            w.op     = OP_CUBE;
            w.jump   = JMP_LEFT;
            w.target = UPC_MUL_SCALE;
         end
         UPC_EMIT: begin
            w.op     = OP_EMIT;
            w.hold   = HOLD_OUT;
            w.jump   = JMP_ALWAYS;
            w.target = UPC_IDLE;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[design/stereo_gain_chase_cubic_saturator.sv]
// ============================================================================
// stereo_gain_chase_cubic_saturator
// Stereo trim with a chasing smoothed gain and cubic soft saturation,
// controlled by a microcoded sequencer over a shared datapath.
// ============================================================================
// rsp_tvalid rises when the emit step registers the shaped pair
// the program handles one stereo pair at a time, paced by the 17-step restoring
//   divider of the chase step and the single shared 28x32 multiplier
// a new req transaction is taken while a finished result waits on rsp
// reset: synchronous; chase speed 350.0, smoothed gain zero and unprimed,
//   trim_gain and last gain at unity, no result pending
`default_nettype none

module stereo_gain_chase_cubic_saturator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: sample_left [23:0], sample_right [47:24]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [47:0]                   req_tdata,
   // rsp_tdata: out_left [23:0], out_right [47:24]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [47:0]                        rsp_tdata,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sgcs_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [sgcs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sgcs_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);
   import sgcs_pkg::*;

   upc_type         pc_ff, pc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [47:0]     rsp_data_ff, rsp_data_in;
   logic [GAIN_W-1:0] trim_ff, trim_in;

   uword_type       uw;
   logic            hold;
   logic            take_jump;
   logic            req_accept;
   logic            csr_write;
   dp_ctl_type      dp_ctl;
   dp_status_type   dp_status;
   logic signed [SAMPLE_W-1:0] res_left;
   logic signed [SAMPLE_W-1:0] res_right;

   assign uw = ucode_rom(pc_ff);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_TRIM_GAIN) ? {15'b0, trim_ff} : '0;

   always_comb begin
      trim_in = trim_ff;
      if (csr_write && (csr_paddr == ADDR_TRIM_GAIN)) begin
         trim_in = csr_pwdata[GAIN_W-1:0];
      end
   end

   always_comb begin
      case (uw.hold)
         HOLD_REQ: hold = ~req_tvalid;
         HOLD_DIV: hold = dp_status.div_busy;
         HOLD_OUT: hold = rsp_valid_ff & ~rsp_tready;
         default:  hold = 1'b0;
      endcase
      case (uw.jump)
         JMP_ALWAYS: take_jump = 1'b1;
         JMP_LEFT:   take_jump = ~dp_status.ch_right;
         default:    take_jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (take_jump) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = (uw.hold == HOLD_REQ);
      req_accept    = req_tvalid & req_tready;
      dp_ctl.op     = uw.op;
      dp_ctl.mul_en = uw.mul_en;
      dp_ctl.mul_a  = uw.mul_a;
      dp_ctl.mul_b  = uw.mul_b;
      dp_ctl.load   = req_accept;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (uw.op == OP_EMIT && !hold) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_right, res_left};
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UPC_IDLE;
         rsp_valid_ff <= 1'b0;
         trim_ff      <= UNITY_GAIN;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         trim_ff      <= trim_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   sgcs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (dp_ctl),
      .sample_left  (req_tdata[23:0]),
      .sample_right (req_tdata[47:24]),
      .trim_gain    (trim_ff),
      .status       (dp_status),
      .res_left     (res_left),
      .res_right    (res_right)
   );

   a_accept_to_prep : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> pc_ff == UPC_PREP)
      else $error("accepted transaction did not start the program");

   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pc_ff) == UPC_EMIT)
      else $error("result raised outside the emit step");

   a_both_channels : assert property (@(posedge clock) disable iff (reset)
      pc_ff == UPC_EMIT |-> !dp_status.ch_right)
      else $error("emit reached with right channel pending");

   a_div_holds : assert property (@(posedge clock) disable iff (reset)
      pc_ff == UPC_DIV_STEP && dp_status.div_busy |=> pc_ff == UPC_DIV_STEP)
      else $error("sequencer left the divider early");

   a_pc_range : assert property (@(posedge clock) disable iff (reset)
      pc_ff <= UPC_EMIT)
      else $error("step counter beyond program");

endmodule

`default_nettype wire

[design/sgcs_datapath.sv]
// ============================================================================
// sgcs_datapath
// Shared multiplier, serial divider and shaper registers driven by the
// microcode control word.
// ============================================================================
`default_nettype none

module sgcs_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sgcs_pkg::dp_ctl_type                  ctl,
   input  wire logic signed [sgcs_pkg::SAMPLE_W-1:0]  sample_left,
   input  wire logic signed [sgcs_pkg::SAMPLE_W-1:0]  sample_right,
   input  wire logic        [sgcs_pkg::GAIN_W-1:0]    trim_gain,
   output sgcs_pkg::dp_status_type                    status,
   output logic signed      [sgcs_pkg::SAMPLE_W-1:0]  res_left,
   output logic signed      [sgcs_pkg::SAMPLE_W-1:0]  res_right
);
   import sgcs_pkg::*;

   logic signed [SAMPLE_W-1:0] samp_l_ff, samp_l_in;
   logic signed [SAMPLE_W-1:0] samp_r_ff, samp_r_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic                       gvalid_ff, gvalid_in;
   logic [GAIN_W-1:0]          last_ff, last_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [46:0]                rem_ff, rem_in;
   logic [44:0]                dsh_ff, dsh_in;
   logic [15:0]                quo_ff, quo_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [24:0]                ymag_ff, ymag_in;
   logic                       yneg_ff, yneg_in;
   logic [25:0]                sq_ff, sq_in;
   logic                       ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] res_l_ff, res_l_in;
   logic signed [SAMPLE_W-1:0] res_r_ff, res_r_in;

   logic signed [SAMPLE_W-1:0] x_cur;
   logic [SAMPLE_W-1:0]        x_mag;
   logic [SPEED_W-1:0]         op_a;
   logic [31:0]                op_b;
   logic [PROD_W-1:0]          mul_full;

   logic [SPEED_W:0]           dbl;
   logic [SPEED_W-1:0]         capped;
   logic [PROD_W-1:0]          dec_sum;
   logic [SPEED_W-1:0]         dec_t;
   logic [SPEED_W:0]           den;
   logic [47:0]                div_diff;
   logic                       div_ge;
   logic [40:0]                scl_sum;
   logic [49:0]                sq_sum;
   logic [50:0]                cu_sum;
   logic [26:0]                cu;
   logic signed [28:0]         diff_s;
   logic signed [28:0]         r_s;
   logic signed [SAMPLE_W-1:0] r_sat;

   // operand selection for the shared multiplier
   always_comb begin
      x_cur = ch_ff ? samp_r_ff : samp_l_ff;
      x_mag = x_cur[SAMPLE_W-1] ? (~x_cur + 24'd1) : x_cur;
      case (ctl.mul_a)
         MA_SPEED: op_a = speed_ff;
         MA_GAIN:  op_a = {11'b0, gain_ff};
         MA_MAG:   op_a = {4'b0, x_mag};
         MA_Y:     op_a = {3'b0, ymag_ff};
         default:  op_a = '0;
      endcase
      case (ctl.mul_b)
         MB_DECAY: op_b = DECAY_MUL;
         MB_SPEED: op_b = {4'b0, speed_ff};
         MB_GAIN:  op_b = {15'b0, gain_ff};
         MB_Y:     op_b = {7'b0, ymag_ff};
         MB_SQ:    op_b = {6'b0, sq_ff};
         default:  op_b = '0;
      endcase
   end

   assign mul_full = {32'b0, op_a} * {28'b0, op_b};

   always_comb begin
      dbl      = (trim_gain != last_ff) ? {speed_ff, 1'b0} : {1'b0, speed_ff};
      capped   = (dbl > {1'b0, SPEED_CAP}) ? SPEED_CAP : dbl[SPEED_W-1:0];
      dec_sum  = prod_ff + 60'd2147483648;
      dec_t    = dec_sum[59:32];
      den      = {1'b0, speed_ff} + 29'd65536;
      div_diff = {1'b0, rem_ff} - {3'b0, dsh_ff};
      div_ge   = ~div_diff[47];
      scl_sum  = prod_ff[40:0] + 41'd32768;
      sq_sum   = prod_ff[49:0] + 50'd4194304;
      cu_sum   = prod_ff[50:0] + 51'd4194304;
      cu       = cu_sum[49:23];
      diff_s   = $signed({4'b0, ymag_ff}) - $signed({2'b0, cu});
      r_s      = yneg_ff ? -diff_s : diff_s;
      if (r_s > 29'sd8388607) begin
         r_sat = 24'sh7FFFFF;
      end else if (r_s < -29'sd8388608) begin
         r_sat = 24'sh800000;
      end else begin
         r_sat = r_s[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      samp_l_in = samp_l_ff;
      samp_r_in = samp_r_ff;
      speed_in  = speed_ff;
      gain_in   = gain_ff;
      gvalid_in = gvalid_ff;
      last_in   = last_ff;
      prod_in   = ctl.mul_en ? mul_full : prod_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      ymag_in   = ymag_ff;
      yneg_in   = yneg_ff;
      sq_in     = sq_ff;
      ch_in     = ch_ff;
      res_l_in  = res_l_ff;
      res_r_in  = res_r_ff;
      if (ctl.load) begin
         samp_l_in = sample_left;
         samp_r_in = sample_right;
      end
      case (ctl.op)
         OP_PREP: begin
            speed_in = capped;
            if (trim_gain != last_ff) begin
               last_in = trim_gain;
            end
            if (!gvalid_ff) begin
               gain_in   = trim_gain;
               gvalid_in = 1'b1;
            end
         end
         OP_DECAY: begin
            speed_in = (dec_t < SPEED_FLOOR_PLUS_SUB) ? SPEED_FLOOR : (dec_t - DECAY_SUB);
         end
         OP_DIV_INIT: begin
            // numerator carries the half-divisor for round to nearest
            rem_in = {2'b0, prod_ff[44:0]} + {14'b0, trim_gain, 16'b0}
                     + {19'b0, den[SPEED_W:1]};
            dsh_in = {den, 16'b0};
            cnt_in = 5'd16;
         end
         OP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[46:0] : rem_ff;
            dsh_in = {1'b0, dsh_ff[44:1]};
            quo_in = {quo_ff[14:0], div_ge};
            if (cnt_ff == 5'd0) begin
               gain_in = {quo_ff, div_ge};
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         OP_SCALE: begin
            ymag_in = scl_sum[40:16];
            yneg_in = x_cur[SAMPLE_W-1];
         end
         OP_SQUARE: begin
            sq_in = sq_sum[48:23];
         end
         OP_CUBE: begin
            if (ch_ff) begin
               res_r_in = r_sat;
            end else begin
               res_l_in = r_sat;
            end
            ch_in = ~ch_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_FLOOR;
         gain_ff   <= '0;
         gvalid_ff <= 1'b0;
         last_ff   <= UNITY_GAIN;
         cnt_ff    <= '0;
         ch_ff     <= 1'b0;
      end else begin
         speed_ff  <= speed_in;
         gain_ff   <= gain_in;
         gvalid_ff <= gvalid_in;
         last_ff   <= last_in;
         cnt_ff    <= cnt_in;
         ch_ff     <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_l_ff <= samp_l_in;
      samp_r_ff <= samp_r_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      ymag_ff   <= ymag_in;
      yneg_ff   <= yneg_in;
      sq_ff     <= sq_in;
      res_l_ff  <= res_l_in;
      res_r_ff  <= res_r_in;
   end

   assign status.div_busy = (cnt_ff != 5'd0);
   assign status.ch_right = ch_ff;
   assign res_left        = res_l_ff;
   assign res_right       = res_r_ff;

endmodule

`default_nettype wire

[verif/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the stereo gain chase cubic saturator. Stereo pairs
// stream in on req, shaped pairs come back on rsp and are checked against a
// bit-accurate prediction of the gain chase and cubic shaper. The trim gain
// is rewritten over the csr port between idle phases, both stream sides idle
// at random, and the result side holds off once long enough to back up req.
// ============================================================================
`timescale 1ns / 100ps

module tb;
   import sgcs_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left;
   } pair_type;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [CSR_AW-1:0] ADDR_STRAY   = 2'd1;
   localparam logic [CSR_DW-1:0] GAIN_FIELD   = (1 << GAIN_W) - 1;
   localparam logic [GAIN_W-1:0] GAIN_MAX     = {GAIN_W{1'b1}};
   localparam longint            HALF_Q32     = 64'h8000_0000;
   localparam longint            HALF_Q23     = 64'h40_0000;
   localparam longint            HALF_Q16     = 64'h8000;
   localparam int                IDLE_PCT     = 20;
   localparam int                HOLD_CYCLES  = 400;
   localparam int                RANDOM_ITEMS = 950;
   localparam int                TAIL_CYCLES  = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // predicted block state
   logic [GAIN_W-1:0]   m_trim   = UNITY_GAIN;
   logic [SPEED_W-1:0]  m_speed  = SPEED_FLOOR;
   logic [GAIN_W-1:0]   m_smooth = '0;
   logic                m_primed = 1'b0;
   logic [GAIN_W-1:0]   m_last   = UNITY_GAIN;

   pair_type            sample_queue[$];
   pair_type            shaped_expected[$];
   bit                  req_taken = 1'b0;
   bit                  steady = 1'b0;
   int unsigned         hold_requests = 0;
   int unsigned         hold_served = 0;
   int unsigned         hold_left = 0;
   int unsigned         mismatches = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   stereo_gain_chase_cubic_saturator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // sample_left [23:0], sample_right [47:24]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // out_left [23:0], out_right [47:24]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic logic [SAMPLE_W-1:0] soft_clip(input logic signed [SAMPLE_W-1:0] x,
                                                     input logic [GAIN_W-1:0] g);
      longint xv, mag, ym, sq, cu, r;
      xv  = x;
      mag = (xv < 0) ? -xv : xv;
      ym  = (mag * longint'(g) + HALF_Q16) >> 16;
      sq  = (ym * ym + HALF_Q23) >> 23;
      cu  = (ym * sq + HALF_Q23) >> 23;
      r   = (xv < 0) ? cu - ym : ym - cu;
      if (r > longint'(FULL_POS))
         r = longint'(FULL_POS);
      else if (r < longint'(FULL_NEG))
         r = longint'(FULL_NEG);
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic pair_type chase_and_shape(input pair_type smp);
      longint   s, den, num;
      pair_type res;
      s = longint'(m_speed);
      if (m_trim != m_last) begin
         s = s * 2;
         m_last = m_trim;
      end
      if (s > longint'(SPEED_CAP))
         s = longint'(SPEED_CAP);
      if (!m_primed) begin
         m_smooth = m_trim;
         m_primed = 1'b1;
      end
      s = (s * longint'(DECAY_MUL) + HALF_Q32) >> 32;
      if (s < longint'(SPEED_FLOOR_PLUS_SUB))
         s = longint'(SPEED_FLOOR);
      else
         s = s - longint'(DECAY_SUB);
      m_speed  = s[SPEED_W-1:0];
      den      = s + longint'(UNITY_GAIN);
      num      = longint'(m_smooth) * s + (longint'(m_trim) << 16);
      num      = (num + den / 2) / den;
      m_smooth = num[GAIN_W-1:0];
      res.left  = soft_clip(smp.left, m_smooth);
      res.right = soft_clip(smp.right, m_smooth);
      return res;
   endfunction

   function automatic logic [SAMPLE_W-1:0] any_sample();
      case ($urandom_range(0, 15))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic push_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
      pair_type p;
      p.left  = l;
      p.right = r;
      sample_queue.push_back(p);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_TRIM_GAIN)
         m_trim = data[GAIN_W-1:0];
      @(posedge clock);
   endtask

   task automatic drain();
      while (sample_queue.size() != 0 || req_tvalid || shaped_expected.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_tdata  <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : monitor
      pair_type got, want;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken)
         shaped_expected.push_back(chase_and_shape(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (shaped_expected.size() == 0) begin
            $error("rsp transaction with nothing expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = shaped_expected.pop_front();
            if (got.left !== want.left) begin
               $error("out_left expected %0d actual %0d", want.left, got.left);
               mismatches++;
            end
            if (got.right !== want.right) begin
               $error("out_right expected %0d actual %0d", want.right, got.right);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned       n, phase, sent;
      logic [GAIN_W-1:0] g;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unity gain from reset, first pair primes the smoothed gain
      push_pair('0, '0);
      push_pair(FULL_POS, FULL_NEG);
      push_pair(FULL_NEG, FULL_POS);
      push_pair('1, 24'sd1);
      push_pair(24'sd1, '1);
      push_pair(any_sample(), any_sample());
      drain();

      // top gain with full-scale input folds the shaper back
      csr_write(ADDR_TRIM_GAIN, CSR_DW'(GAIN_MAX));
      push_pair(FULL_POS, FULL_NEG);
      push_pair(FULL_NEG, FULL_POS);
      push_pair(24'sh400000, -24'sh400000);
      push_pair(any_sample(), any_sample());
      drain();

      // back-to-back writes, speed doubles only once
      csr_write(ADDR_TRIM_GAIN, '0);
      csr_write(ADDR_TRIM_GAIN, 32'd20000);
      push_pair(FULL_POS, FULL_NEG);
      push_pair(any_sample(), any_sample());
      push_pair(any_sample(), any_sample());
      drain();

      csr_write(ADDR_TRIM_GAIN, '0);
      push_pair(FULL_POS, FULL_NEG);
      push_pair(any_sample(), any_sample());
      drain();

      // stray address carrying the current gain in its low bits
      csr_write(ADDR_STRAY, ($urandom & ~GAIN_FIELD) | CSR_DW'(m_trim));
      push_pair(FULL_NEG, FULL_POS);
      push_pair(any_sample(), any_sample());
      drain();

      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = GAIN_MAX;
            2:       g = UNITY_GAIN;
            3:       g = m_trim;
            default: g = GAIN_W'($urandom_range(0, GAIN_MAX));
         endcase
         if ($urandom_range(0, 7) == 0)
            csr_write(ADDR_TRIM_GAIN, $urandom);
         csr_write(ADDR_TRIM_GAIN, ($urandom & ~GAIN_FIELD) | CSR_DW'(g));
         // short phases let repeated gain changes drive the speed to its cap
         if (phase == 2 || phase == 4)
            n = 120;
         else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, 6);
         else
            n = $urandom_range(20, 120);
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         steady = (phase == 4);
         repeat (n) push_pair(any_sample(), any_sample());
         if (phase == 2)
            hold_requests++;
         drain();
         steady = 1'b0;
         sent  += n;
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && shaped_expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

[stereo_gain_chase_cubic_saturator.f]
design/sgcs_pkg.sv
design/sgcs_datapath.sv
design/stereo_gain_chase_cubic_saturator.sv
verif/tb.sv
